FILE: hw/rtl/rkt_pkg.sv
`timescale 1ns / 1ps
package rkt_pkg;

   localparam int ANCHOR_COUNT = 3;
   localparam int ANCHOR_W = 2;
   localparam int ADDR_W = 48;
   localparam int POS_W = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   localparam int DIV_NUM_W = 54;
   localparam int DIV_DEN_W = 38;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

   // ceil(2^22 / 25): multiplying by this and shifting right by 22 divides by 25 exactly
   // for every dividend whose quotient stays within the 4096 clamp of the network input.
   localparam logic [17:0] XN_RECIP = 18'd167773;
   localparam int XN_RECIP_SHIFT = 22;

   localparam logic [CSR_INDEX_W-1:0] REG_ANCHOR0_ADDR = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ANCHOR1_ADDR = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ANCHOR2_ADDR = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ANCHOR0_POS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ANCHOR1_POS = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_ANCHOR2_POS = 3'd5;

   localparam logic [POS_W-1:0] ANCHOR0_POS_RESET = 32'h0000_0000;
   localparam logic [POS_W-1:0] ANCHOR1_POS_RESET = 32'h0000_0B33;
   localparam logic [POS_W-1:0] ANCHOR2_POS_RESET = 32'h0B33_0000;

   typedef struct packed {
      logic [ANCHOR_W-1:0] anchor;
      logic signed [7:0]   rssi;
   } rkt_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } rkt_qstat_type;

   typedef struct packed {
      logic busy;
      logic done;
   } rkt_div_stat_type;

   function automatic logic signed [16:0] w1_val(input logic [2:0] i);
      case (i)
         3'd0: w1_val = 17'sd17394;
         3'd1: w1_val = -17'sd33642;
         3'd2: w1_val = 17'sd1800;
         3'd3: w1_val = 17'sd3780;
         3'd4: w1_val = -17'sd50833;
         default: w1_val = 17'sd0;
      endcase
   endfunction

   function automatic logic signed [16:0] b1_val(input logic [2:0] i);
      case (i)
         3'd0: b1_val = -17'sd24473;
         3'd1: b1_val = 17'sd13701;
         3'd2: b1_val = -17'sd3143;
         3'd3: b1_val = -17'sd12328;
         3'd4: b1_val = 17'sd9266;
         default: b1_val = 17'sd0;
      endcase
   endfunction

   function automatic logic signed [16:0] w2_val(input logic [2:0] i);
      case (i)
         3'd0: w2_val = 17'sd52272;
         3'd1: w2_val = 17'sd19150;
         3'd2: w2_val = -17'sd11668;
         3'd3: w2_val = -17'sd55874;
         3'd4: w2_val = -17'sd7780;
         default: w2_val = 17'sd0;
      endcase
   endfunction

   function automatic logic [11:0] sig_tab(input logic [4:0] i);
      case (i)
         5'd0: sig_tab = 12'd2048;
         5'd1: sig_tab = 12'd2550;
         5'd2: sig_tab = 12'd2994;
         5'd3: sig_tab = 12'd3349;
         5'd4: sig_tab = 12'd3608;
         5'd5: sig_tab = 12'd3785;
         5'd6: sig_tab = 12'd3902;
         5'd7: sig_tab = 12'd3976;
         5'd8: sig_tab = 12'd4022;
         5'd9: sig_tab = 12'd4051;
         5'd10: sig_tab = 12'd4069;
         5'd11: sig_tab = 12'd4079;
         5'd12: sig_tab = 12'd4086;
         5'd13: sig_tab = 12'd4090;
         5'd14: sig_tab = 12'd4092;
         5'd15: sig_tab = 12'd4094;
         default: sig_tab = 12'd4095;
      endcase
   endfunction

   // Sigmoid in Q.12, linear interpolation between half-unit samples.
   function automatic logic [12:0] sig_q12(input logic signed [18:0] z);
      logic [18:0] az;
      logic [7:0]  idx;
      logic [10:0] frac;
      logic [11:0] lo;
      logic [11:0] step;
      logic [22:0] ip;
      logic [11:0] sp;
      az = z[18] ? 19'(-z) : 19'(z);
      idx = az[18:11];
      frac = az[10:0];
      lo = sig_tab(idx[4:0]);
      step = 12'(sig_tab(5'(idx[4:0] + 5'd1)) - lo);
      ip = 23'(step) * 23'(frac) + 23'd1024;
      if (idx >= 8'd16) begin
         sp = 12'd4095;
      end else begin
         sp = 12'(lo + 12'(ip >> 11));
      end
      sig_q12 = z[18] ? 13'(13'd4096 - {1'b0, sp}) : {1'b0, sp};
   endfunction

endpackage

FILE: hw/rtl/rkt_if.sv
`timescale 1ns / 1ps
interface rkt_req_if;
   logic                           valid;
   logic                           ready;
   logic [rkt_pkg::ADDR_W-1:0]     source_address;
   logic signed [7:0]              signal_strength;
   modport source (output valid, output source_address, output signal_strength, input ready);
   modport sink (input valid, input source_address, input signal_strength, output ready);
endinterface

interface rkt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] position_x;
   logic signed [23:0] position_y;
   logic               solved;
   modport source (output valid, output position_x, output position_y, output solved,
                   input ready);
   modport sink (input valid, input position_x, input position_y, input solved,
                 output ready);
endinterface

interface rkt_csr_if;
   logic                            valid;
   logic                            ready;
   logic [rkt_pkg::CSR_INDEX_W-1:0] index;
   logic [rkt_pkg::ADDR_W-1:0]      data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/rssi_kalman_trilateration.sv
`timescale 1ns / 1ps
// RSSI ranging and 2D trilateration engine. Each req transaction carries a frame's
// 48-bit sender address and its signed RSSI in dBm. The front end compares the sender
// with the three anchor addresses (lowest index wins on duplicates), drops frames from
// unknown senders at once, and queues matches in a four-entry queue, so req stays
// ready while the back end works unless that queue is full. The back end runs, per
// queued frame, a scalar Kalman update (Q = 0.05, R = 9) on that anchor's Q8.8 estimate,
// a 1-5-1 sigmoid network that maps it to a distance clamped to 0.01..5 m (Q3.12), and,
// once all three anchors are fresh, a trilateration whose Q12.12 saturated position is
// offered as one rsp transaction; solved is 0 with a zero position when the geometry is
// degenerate.
// A queued frame's time is set mostly by one pass of the one-bit-per-cycle 54-bit
// divider for the Kalman gain and by the network on the shared multiplier; a frame
// that completes a set takes longer, for the fifteen multiplies and the two position
// divides. A pending rsp holds the back end only when a second result is ready.
// CSR writes (index 0..2 anchor addresses, 3..5 packed x/y positions) are always
// accepted and must be issued only while the block is idle.
module rssi_kalman_trilateration (
   input logic       clock,
   input logic       reset,
   rkt_req_if.sink   req_ch,
   rkt_rsp_if.source rsp_ch,
   rkt_csr_if.sink   csr_ch
);

   localparam int NA = rkt_pkg::ANCHOR_COUNT;

   logic [rkt_pkg::ADDR_W-1:0] addr_ff [NA];
   logic [rkt_pkg::ADDR_W-1:0] addr_in [NA];
   logic [rkt_pkg::POS_W-1:0]  pos_ff [NA];
   logic [rkt_pkg::POS_W-1:0]  pos_in [NA];

   logic                   push, pop;
   rkt_pkg::rkt_entry_type push_entry, head;
   rkt_pkg::rkt_qstat_type qstat;

   // The CSR port never stalls.
   assign csr_ch.ready = 1'b1;

   always_comb begin
      for (int m = 0; m < NA; m++) begin
         addr_in[m] = addr_ff[m];
         pos_in[m] = pos_ff[m];
      end
      if (csr_ch.valid) begin
         case (csr_ch.index)
            rkt_pkg::REG_ANCHOR0_ADDR: addr_in[0] = csr_ch.data;
            rkt_pkg::REG_ANCHOR1_ADDR: addr_in[1] = csr_ch.data;
            rkt_pkg::REG_ANCHOR2_ADDR: addr_in[2] = csr_ch.data;
            rkt_pkg::REG_ANCHOR0_POS: pos_in[0] = csr_ch.data[rkt_pkg::POS_W-1:0];
            rkt_pkg::REG_ANCHOR1_POS: pos_in[1] = csr_ch.data[rkt_pkg::POS_W-1:0];
            rkt_pkg::REG_ANCHOR2_POS: pos_in[2] = csr_ch.data[rkt_pkg::POS_W-1:0];
            default: begin
               // Writes beyond the register list are ignored.
               pos_in[0] = pos_ff[0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < NA; m++) begin
            addr_ff[m] <= '0;
         end
         pos_ff[0] <= rkt_pkg::ANCHOR0_POS_RESET;
         pos_ff[1] <= rkt_pkg::ANCHOR1_POS_RESET;
         pos_ff[2] <= rkt_pkg::ANCHOR2_POS_RESET;
      end else begin
         for (int m = 0; m < NA; m++) begin
            addr_ff[m] <= addr_in[m];
            pos_ff[m] <= pos_in[m];
         end
      end
   end

   rkt_front u_front (
      .req     (req_ch),
      .addr_i  (addr_ff),
      .qstat_i (qstat),
      .push_o  (push),
      .entry_o (push_entry)
   );

   rkt_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_i      (push),
      .push_data_i (push_entry),
      .pop_i       (pop),
      .head_o      (head),
      .qstat_o     (qstat)
   );

   rkt_back u_back (
      .clock   (clock),
      .reset   (reset),
      .qstat_i (qstat),
      .head_i  (head),
      .pop_o   (pop),
      .pos_i   (pos_ff),
      .rsp     (rsp_ch)
   );

endmodule

FILE: hw/rtl/rkt_front.sv
`timescale 1ns / 1ps
module rkt_front (
   rkt_req_if.sink                 req,
   input  logic [rkt_pkg::ADDR_W-1:0] addr_i [rkt_pkg::ANCHOR_COUNT],
   input  rkt_pkg::rkt_qstat_type  qstat_i,
   output logic                    push_o,
   output rkt_pkg::rkt_entry_type  entry_o
);

   logic accept;
   logic [rkt_pkg::ANCHOR_COUNT-1:0] hit;

   assign req.ready = !qstat_i.full;
   assign accept = req.valid && !qstat_i.full;

   always_comb begin
      for (int m = 0; m < rkt_pkg::ANCHOR_COUNT; m++) begin
         hit[m] = (req.source_address == addr_i[m]);
      end
   end

   // The lowest-numbered matching anchor wins; unknown senders are dropped here.
   always_comb begin
      entry_o.rssi = req.signal_strength;
      entry_o.anchor = 2'd0;
      if (hit[0]) begin
         entry_o.anchor = 2'd0;
      end else if (hit[1]) begin
         entry_o.anchor = 2'd1;
      end else begin
         entry_o.anchor = 2'd2;
      end
      push_o = accept && (hit != '0);
   end

endmodule

FILE: hw/rtl/rkt_queue.sv
`timescale 1ns / 1ps
module rkt_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_i,
   input  rkt_pkg::rkt_entry_type push_data_i,
   input  logic                   pop_i,
   output rkt_pkg::rkt_entry_type head_o,
   output rkt_pkg::rkt_qstat_type qstat_o
);

   rkt_pkg::rkt_entry_type slot_ff [rkt_pkg::QUEUE_DEPTH];
   logic [rkt_pkg::QUEUE_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [rkt_pkg::QUEUE_PTR_W:0]   count_ff, count_in;

   assign head_o = slot_ff[rd_ff];
   assign qstat_o.full = (count_ff == (rkt_pkg::QUEUE_PTR_W + 1)'(rkt_pkg::QUEUE_DEPTH));
   assign qstat_o.empty = (count_ff == '0);

   always_comb begin
      wr_in = push_i ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop_i ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (push_i && !pop_i) begin
         count_in = count_ff + 1'b1;
      end else if (pop_i && !push_i) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         slot_ff[wr_ff] <= push_data_i;
      end
   end

endmodule

FILE: hw/rtl/rkt_div.sv
`timescale 1ns / 1ps
module rkt_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start_i,
   input  logic signed [rkt_pkg::DIV_NUM_W-1:0] num_i,
   input  logic signed [rkt_pkg::DIV_DEN_W-1:0] den_i,
   output rkt_pkg::rkt_div_stat_type            stat_o,
   output logic signed [rkt_pkg::DIV_NUM_W-1:0] quot_o
);

   localparam int NW = rkt_pkg::DIV_NUM_W;
   localparam int DW = rkt_pkg::DIV_DEN_W;

   logic                          busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic [rkt_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW:0]                   rem_ff, rem_in, trial;
   logic [NW-1:0]                 dq_ff, dq_in;
   logic [DW-1:0]                 dmag_ff, dmag_in;

   assign stat_o.busy = busy_ff;
   assign stat_o.done = done_ff;
   // Truncating signed quotient: divide magnitudes and fix the sign at the end.
   assign quot_o = neg_ff ? NW'(-$signed(dq_ff)) : $signed(dq_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dq_in = dq_ff;
      dmag_in = dmag_ff;
      trial = {rem_ff[DW-1:0], dq_ff[NW-1]};
      if (start_i) begin
         busy_in = 1'b1;
         neg_in = num_i[NW-1] ^ den_i[DW-1];
         cnt_in = rkt_pkg::DIV_CNT_W'(NW);
         rem_in = '0;
         dq_in = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
         dmag_in = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
      end else if (busy_ff) begin
         if (trial >= {1'b0, dmag_ff}) begin
            rem_in = trial - {1'b0, dmag_ff};
            dq_in = {dq_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            dq_in = {dq_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == rkt_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      dq_ff <= dq_in;
      dmag_ff <= dmag_in;
   end

endmodule

FILE: hw/rtl/rkt_back.sv
`timescale 1ns / 1ps
module rkt_back (
   input  logic                       clock,
   input  logic                       reset,
   input  rkt_pkg::rkt_qstat_type     qstat_i,
   input  rkt_pkg::rkt_entry_type     head_i,
   output logic                       pop_o,
   input  logic [rkt_pkg::POS_W-1:0]  pos_i [rkt_pkg::ANCHOR_COUNT],
   rkt_rsp_if.source                  rsp
);

   typedef enum logic [17:0] {
      ST_IDLE   = 18'h00001,
      ST_K_DIV  = 18'h00002,
      ST_K_MUL  = 18'h00004,
      ST_K_UPD1 = 18'h00008,
      ST_K_UPD2 = 18'h00010,
      ST_N_DIV  = 18'h00020,
      ST_N_MZ   = 18'h00040,
      ST_N_Z    = 18'h00080,
      ST_N_SIG  = 18'h00100,
      ST_N_MA   = 18'h00200,
      ST_N_ACC  = 18'h00400,
      ST_N_DIST = 18'h00800,
      ST_T_MUL  = 18'h01000,
      ST_T_ACC  = 18'h02000,
      ST_T_CHK  = 18'h04000,
      ST_T_DIVX = 18'h08000,
      ST_T_DIVY = 18'h10000,
      ST_EMIT   = 18'h20000
   } state_type;

   localparam int NA = rkt_pkg::ANCHOR_COUNT;

   state_type state_ff, state_in;
   logic [1:0]          k_ff, k_in;
   logic signed [7:0]   rssi_ff, rssi_in;
   logic [16:0]         pp_ff, pp_in;
   logic [14:0]         gain_ff, gain_in;
   logic [12:0]         xn_ff, xn_in;
   logic [2:0]          idx_ff, idx_in;
   logic signed [18:0]  z_ff, z_in;
   logic [12:0]         sig_ff, sig_in;
   logic signed [23:0]  acc_ff, acc_in;
   logic [3:0]          tstep_ff, tstep_in;
   logic signed [32:0]  sq_ff [NA];
   logic signed [32:0]  sq_in [NA];
   logic signed [52:0]  tmp_ff, tmp_in;
   logic signed [36:0]  det_ff, det_in;
   logic signed [53:0]  numx_ff, numx_in, numy_ff, numy_in;
   logic signed [23:0]  resx_ff, resx_in, resy_ff, resy_in;
   logic                solved_ff, solved_in;
   logic signed [15:0]  est_ff [NA];
   logic signed [15:0]  est_in [NA];
   logic [15:0]         cov_ff [NA];
   logic [15:0]         cov_in [NA];
   logic [14:0]         dist_ff [NA];
   logic [14:0]         dist_in [NA];
   logic [NA-1:0]       fresh_ff, fresh_in;
   logic                out_valid_ff, out_valid_in;
   logic signed [23:0]  out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic                out_s_ff, out_s_in;

   logic signed [33:0]  mul_a;
   logic signed [18:0]  mul_b;
   logic signed [52:0]  mul_p_ff, mul_p_in;

   logic                              div_start;
   logic signed [rkt_pkg::DIV_NUM_W-1:0] div_num, div_quot;
   logic signed [rkt_pkg::DIV_DEN_W-1:0] div_den;
   rkt_pkg::rkt_div_stat_type         div_stat;

   logic signed [17:0]  diff, est_sum, t_val;
   logic signed [52:0]  p_rnd14, p_rnd12, z_sum;
   logic [52:0]         pn;
   logic [14:0]         omg;
   logic [16:0]         pp_head;
   logic [17:0]         den_head;
   logic [17:0]         xn_num;
   logic [35:0]         xn_prod;
   logic [13:0]         xn_quo;
   logic signed [15:0]  px [NA];
   logic signed [15:0]  py [NA];
   logic signed [17:0]  a1, b1, a2, b2;
   logic signed [33:0]  c1, c2;
   logic                det_ok, emit_load;

   function automatic logic signed [52:0] rnd_shr(input logic signed [52:0] v,
                                                  input int unsigned sh);
      logic signed [52:0] half;
      half = 53'sd1 <<< (sh - 1);
      if (v >= 0) begin
         rnd_shr = (v + half) >>> sh;
      end else begin
         rnd_shr = -((-v + half) >>> sh);
      end
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [53:0] v);
      if (v > 54'sd8388607) begin
         sat24 = 24'sh7FFFFF;
      end else if (v < -54'sd8388608) begin
         sat24 = -24'sd8388608;
      end else begin
         sat24 = 24'(v);
      end
   endfunction

   rkt_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start_i (div_start),
      .num_i   (div_num),
      .den_i   (div_den),
      .stat_o  (div_stat),
      .quot_o  (div_quot)
   );

   assign rsp.valid = out_valid_ff;
   assign rsp.position_x = out_x_ff;
   assign rsp.position_y = out_y_ff;
   assign rsp.solved = out_s_ff;

   always_comb begin
      for (int m = 0; m < NA; m++) begin
         px[m] = pos_i[m][31:16];
         py[m] = pos_i[m][15:0];
      end
      a1 = (18'(px[1]) - 18'(px[0])) <<< 1;
      b1 = (18'(py[1]) - 18'(py[0])) <<< 1;
      a2 = (18'(px[2]) - 18'(px[0])) <<< 1;
      b2 = (18'(py[2]) - 18'(py[0])) <<< 1;
      c1 = 34'(sq_ff[0]) - 34'(sq_ff[1]);
      c2 = 34'(sq_ff[0]) - 34'(sq_ff[2]);
      det_ok = (det_ff >= 37'sd1678) || (det_ff <= -37'sd1678);

      diff = (18'(rssi_ff) <<< 8) - 18'(est_ff[k_ff]);
      p_rnd14 = rnd_shr(mul_p_ff, 14);
      p_rnd12 = rnd_shr(mul_p_ff, 12);
      est_sum = 18'(est_ff[k_ff]) + 18'(p_rnd14);
      pn = 53'(mul_p_ff + 53'sd8192) >> 14;
      omg = 15'(15'd16384 - gain_ff);
      t_val = 18'(est_ff[k_ff]) + 18'sd25600;
      // Network input (4t + 12) / 25 by reciprocal multiplication; only used when t > 0.
      xn_num = {t_val[15:0], 2'b00} + 18'd12;
      xn_prod = 36'(xn_num) * 36'(rkt_pkg::XN_RECIP);
      xn_quo = 14'(xn_prod >> rkt_pkg::XN_RECIP_SHIFT);
      z_sum = p_rnd12 + 53'(rkt_pkg::b1_val(idx_ff));
      pp_head = 17'(cov_ff[head_i.anchor]) + 17'd819;
      den_head = 18'(pp_head) + 18'd147456;
   end

   // One shared multiplier; its product is registered and used in the next state.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_K_MUL: begin
            mul_a = 34'(diff);
            mul_b = $signed({4'b0, gain_ff});
         end
         ST_K_UPD1: begin
            mul_a = $signed({17'b0, pp_ff});
            mul_b = $signed({4'b0, omg});
         end
         ST_N_MZ: begin
            mul_a = 34'(rkt_pkg::w1_val(idx_ff));
            mul_b = $signed({6'b0, xn_ff});
         end
         ST_N_MA: begin
            mul_a = 34'(rkt_pkg::w2_val(idx_ff));
            mul_b = $signed({6'b0, sig_ff});
         end
         ST_T_MUL: begin
            case (tstep_ff)
               4'd0: begin mul_a = $signed({19'b0, dist_ff[0]}); mul_b = $signed({4'b0, dist_ff[0]}); end
               4'd1: begin mul_a = 34'(px[0]); mul_b = 19'(px[0]); end
               4'd2: begin mul_a = 34'(py[0]); mul_b = 19'(py[0]); end
               4'd3: begin mul_a = $signed({19'b0, dist_ff[1]}); mul_b = $signed({4'b0, dist_ff[1]}); end
               4'd4: begin mul_a = 34'(px[1]); mul_b = 19'(px[1]); end
               4'd5: begin mul_a = 34'(py[1]); mul_b = 19'(py[1]); end
               4'd6: begin mul_a = $signed({19'b0, dist_ff[2]}); mul_b = $signed({4'b0, dist_ff[2]}); end
               4'd7: begin mul_a = 34'(px[2]); mul_b = 19'(px[2]); end
               4'd8: begin mul_a = 34'(py[2]); mul_b = 19'(py[2]); end
               4'd9: begin mul_a = 34'(a1); mul_b = 19'(b2); end
               4'd10: begin mul_a = 34'(a2); mul_b = 19'(b1); end
               4'd11: begin mul_a = c1; mul_b = 19'(b2); end
               4'd12: begin mul_a = c2; mul_b = 19'(b1); end
               4'd13: begin mul_a = c2; mul_b = 19'(a1); end
               4'd14: begin mul_a = c1; mul_b = 19'(a2); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p_in = mul_a * mul_b;
   end

   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      rssi_in = rssi_ff;
      pp_in = pp_ff;
      gain_in = gain_ff;
      xn_in = xn_ff;
      idx_in = idx_ff;
      z_in = z_ff;
      sig_in = sig_ff;
      acc_in = acc_ff;
      tstep_in = tstep_ff;
      tmp_in = tmp_ff;
      det_in = det_ff;
      numx_in = numx_ff;
      numy_in = numy_ff;
      resx_in = resx_ff;
      resy_in = resy_ff;
      solved_in = solved_ff;
      fresh_in = fresh_ff;
      for (int m = 0; m < NA; m++) begin
         sq_in[m] = sq_ff[m];
         est_in[m] = est_ff[m];
         cov_in[m] = cov_ff[m];
         dist_in[m] = dist_ff[m];
      end
      out_x_in = out_x_ff;
      out_y_in = out_y_ff;
      out_s_in = out_s_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      pop_o = 1'b0;
      div_start = 1'b0;
      div_num = '0;
      div_den = '0;
      emit_load = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!qstat_i.empty) begin
               pop_o = 1'b1;
               k_in = head_i.anchor;
               rssi_in = head_i.rssi;
               pp_in = pp_head;
               div_start = 1'b1;
               div_num = (54'(pp_head) <<< 14) + 54'(den_head >> 1);
               div_den = 38'(den_head);
               state_in = ST_K_DIV;
            end
         end
         ST_K_DIV: begin
            if (div_stat.done) begin
               gain_in = div_quot[14:0];
               state_in = ST_K_MUL;
            end
         end
         ST_K_MUL: begin
            state_in = ST_K_UPD1;
         end
         ST_K_UPD1: begin
            if (est_sum > 18'sd32767) begin
               est_in[k_ff] = 16'sh7FFF;
            end else if (est_sum < -18'sd32768) begin
               est_in[k_ff] = -16'sd32768;
            end else begin
               est_in[k_ff] = 16'(est_sum);
            end
            state_in = ST_K_UPD2;
         end
         ST_K_UPD2: begin
            cov_in[k_ff] = (pn > 53'd65535) ? 16'hFFFF : pn[15:0];
            idx_in = '0;
            acc_in = 24'sd853;
            if (t_val <= 18'sd0) begin
               xn_in = '0;
               state_in = ST_N_MZ;
            end else begin
               state_in = ST_N_DIV;
            end
         end
         ST_N_DIV: begin
            xn_in = (xn_quo > 14'd4096) ? 13'd4096 : xn_quo[12:0];
            state_in = ST_N_MZ;
         end
         ST_N_MZ: begin
            state_in = ST_N_Z;
         end
         ST_N_Z: begin
            if (z_sum > 53'sd204800) begin
               z_in = 19'sd204800;
            end else if (z_sum < -53'sd204800) begin
               z_in = -19'sd204800;
            end else begin
               z_in = 19'(z_sum);
            end
            state_in = ST_N_SIG;
         end
         ST_N_SIG: begin
            sig_in = rkt_pkg::sig_q12(z_ff);
            state_in = ST_N_MA;
         end
         ST_N_MA: begin
            state_in = ST_N_ACC;
         end
         ST_N_ACC: begin
            acc_in = acc_ff + 24'(p_rnd12);
            if (idx_ff == 3'd4) begin
               state_in = ST_N_DIST;
            end else begin
               idx_in = idx_ff + 3'd1;
               state_in = ST_N_MZ;
            end
         end
         ST_N_DIST: begin
            if (acc_ff < 24'sd0) begin
               dist_in[k_ff] = 15'd41;
            end else if (acc_ff > 24'sd20480) begin
               dist_in[k_ff] = 15'd20480;
            end else begin
               dist_in[k_ff] = acc_ff[14:0];
            end
            fresh_in[k_ff] = 1'b1;
            tstep_in = '0;
            if ((fresh_ff | (NA'(1) << k_ff)) == {NA{1'b1}}) begin
               state_in = ST_T_MUL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_T_MUL: begin
            state_in = ST_T_ACC;
         end
         ST_T_ACC: begin
            case (tstep_ff)
               4'd0: sq_in[0] = 33'(mul_p_ff);
               4'd1, 4'd2: sq_in[0] = sq_ff[0] - 33'(mul_p_ff);
               4'd3: sq_in[1] = 33'(mul_p_ff);
               4'd4, 4'd5: sq_in[1] = sq_ff[1] - 33'(mul_p_ff);
               4'd6: sq_in[2] = 33'(mul_p_ff);
               4'd7, 4'd8: sq_in[2] = sq_ff[2] - 33'(mul_p_ff);
               4'd9, 4'd11, 4'd13: tmp_in = mul_p_ff;
               4'd10: det_in = 37'(tmp_ff - mul_p_ff);
               4'd12: numx_in = 54'(tmp_ff) - 54'(mul_p_ff);
               4'd14: numy_in = 54'(tmp_ff) - 54'(mul_p_ff);
               default: tmp_in = tmp_ff;
            endcase
            if (tstep_ff == 4'd14) begin
               state_in = ST_T_CHK;
            end else begin
               tstep_in = tstep_ff + 4'd1;
               state_in = ST_T_MUL;
            end
         end
         ST_T_CHK: begin
            if (det_ok) begin
               div_start = 1'b1;
               div_num = numx_ff;
               div_den = 38'(det_ff);
               state_in = ST_T_DIVX;
            end else begin
               resx_in = '0;
               resy_in = '0;
               solved_in = 1'b0;
               state_in = ST_EMIT;
            end
         end
         ST_T_DIVX: begin
            if (div_stat.done) begin
               resx_in = sat24(div_quot);
               div_start = 1'b1;
               div_num = numy_ff;
               div_den = 38'(det_ff);
               state_in = ST_T_DIVY;
            end
         end
         ST_T_DIVY: begin
            if (div_stat.done) begin
               resy_in = sat24(div_quot);
               solved_in = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp.ready) begin
               emit_load = 1'b1;
               out_valid_in = 1'b1;
               out_x_in = resx_ff;
               out_y_in = resy_ff;
               out_s_in = solved_ff;
               fresh_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fresh_ff <= '0;
         out_valid_ff <= 1'b0;
         idx_ff <= '0;
         tstep_ff <= '0;
         for (int m = 0; m < NA; m++) begin
            est_ff[m] <= '0;
            cov_ff[m] <= 16'd16384;
            dist_ff[m] <= '0;
         end
      end else begin
         state_ff <= state_in;
         fresh_ff <= fresh_in;
         out_valid_ff <= out_valid_in;
         idx_ff <= idx_in;
         tstep_ff <= tstep_in;
         for (int m = 0; m < NA; m++) begin
            est_ff[m] <= est_in[m];
            cov_ff[m] <= cov_in[m];
            dist_ff[m] <= dist_in[m];
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      rssi_ff <= rssi_in;
      pp_ff <= pp_in;
      gain_ff <= gain_in;
      xn_ff <= xn_in;
      z_ff <= z_in;
      sig_ff <= sig_in;
      acc_ff <= acc_in;
      tmp_ff <= tmp_in;
      det_ff <= det_in;
      numx_ff <= numx_in;
      numy_ff <= numy_in;
      resx_ff <= resx_in;
      resy_ff <= resy_in;
      solved_ff <= solved_in;
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      out_s_ff <= out_s_in;
      mul_p_ff <= mul_p_in;
      for (int m = 0; m < NA; m++) begin
         sq_ff[m] <= sq_in[m];
      end
   end

   a_div_quiet_in_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_stat.busy)
      else $error("divider busy while the sequencer is idle");

   a_unsolved_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.solved) |-> (rsp.position_x == '0 && rsp.position_y == '0))
      else $error("degenerate result carries a nonzero position");

   a_flags_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && emit_load) |=> (fresh_ff == '0))
      else $error("fresh flags survive a delivered result");

endmodule

FILE: tb/tb_rssi_kalman_trilateration.sv
`timescale 1ns / 1ps

// One trilateration result as it leaves the rsp channel.
typedef struct {
   logic signed [23:0] x;
   logic signed [23:0] y;
   logic               solved;
} position_fix_type;

// Tracks the ranging state of all three anchors and keeps the queue of position
// fixes that the block still owes.
class ranging_scoreboard;
   logic [47:0]  anchor_addr[3];
   logic [31:0]  anchor_pos[3];
   longint       rssi_est[3];
   longint       covariance[3];
   longint       distance[3];
   bit           fresh[3];
   position_fix_type owed[$];
   int           mismatches;

   function void clear();
      foreach (rssi_est[k]) begin
         anchor_addr[k] = '0;
         rssi_est[k] = 0;
         covariance[k] = 16384;
         distance[k] = 0;
         fresh[k] = 0;
      end
      anchor_pos[0] = rkt_pkg::ANCHOR0_POS_RESET;
      anchor_pos[1] = rkt_pkg::ANCHOR1_POS_RESET;
      anchor_pos[2] = rkt_pkg::ANCHOR2_POS_RESET;
      owed.delete();
      mismatches = 0;
   endfunction

   function void write_reg(logic [rkt_pkg::CSR_INDEX_W-1:0] idx, logic [47:0] data);
      case (idx)
         rkt_pkg::REG_ANCHOR0_ADDR: anchor_addr[0] = data;
         rkt_pkg::REG_ANCHOR1_ADDR: anchor_addr[1] = data;
         rkt_pkg::REG_ANCHOR2_ADDR: anchor_addr[2] = data;
         rkt_pkg::REG_ANCHOR0_POS: anchor_pos[0] = data[31:0];
         rkt_pkg::REG_ANCHOR1_POS: anchor_pos[1] = data[31:0];
         rkt_pkg::REG_ANCHOR2_POS: anchor_pos[2] = data[31:0];
         default: ;
      endcase
   endfunction

   // Right shift with rounding half away from zero.
   function longint shift_round(longint v, int s);
      longint half;
      half = longint'(1) << (s - 1);
      if (v >= 0) return (v + half) >>> s;
      return -((-v + half) >>> s);
   endfunction

   function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function longint sigmoid(longint z);
      longint mag, idx, frac, s;
      z = clip(z, -204800, 204800);
      mag = z < 0 ? -z : z;
      idx = mag >>> 11;
      frac = mag & 2047;
      if (idx >= 16) s = 4095;
      else s = rkt_pkg::sig_tab(5'(idx)) +
               (((longint'(rkt_pkg::sig_tab(5'(idx + 1))) - rkt_pkg::sig_tab(5'(idx)))
                 * frac + 1024) >>> 11);
      return z < 0 ? 4096 - s : s;
   endfunction

   function longint range_of(longint est);
      longint t, xn, z, net;
      t = est + 25600;
      xn = t <= 0 ? 0 : (t * 4 + 12) / 25;
      if (xn > 4096) xn = 4096;
      net = 853;
      for (int i = 0; i < 5; i++) begin
         z = shift_round(xn * longint'(rkt_pkg::w1_val(3'(i))), 12)
             + longint'(rkt_pkg::b1_val(3'(i)));
         net += shift_round(sigmoid(z) * longint'(rkt_pkg::w2_val(3'(i))), 12);
      end
      if (net < 0) return 41;
      if (net > 20480) return 20480;
      return net;
   endfunction

   function void filter(int k, longint rssi);
      longint pp, gain, diff, pn;
      pp = covariance[k] + 819;
      gain = ((pp << 14) + ((pp + 147456) >>> 1)) / (pp + 147456);
      diff = rssi * 256 - rssi_est[k];
      rssi_est[k] = clip(rssi_est[k] + shift_round(gain * diff, 14), -32768, 32767);
      pn = ((16384 - gain) * pp + 8192) >>> 14;
      covariance[k] = pn > 65535 ? 65535 : pn;
   endfunction

   function longint px(int k);
      return longint'($signed(anchor_pos[k][31:16]));
   endfunction

   function longint py(int k);
      return longint'($signed(anchor_pos[k][15:0]));
   endfunction

   function longint square_term(int k);
      return distance[k] * distance[k] - px(k) * px(k) - py(k) * py(k);
   endfunction

   // Accepted frame: update the matching anchor and, once all three are fresh,
   // add the position fix to the owed queue.
   function void note_frame(logic [47:0] addr, logic signed [7:0] rssi);
      longint a1, b1, c1, a2, b2, c2, det;
      position_fix_type fix;
      for (int k = 0; k < 3; k++) begin
         if (addr == anchor_addr[k]) begin
            filter(k, longint'(rssi));
            distance[k] = range_of(rssi_est[k]);
            fresh[k] = 1;
            break;
         end
      end
      if (!(fresh[0] && fresh[1] && fresh[2])) return;
      a1 = 2 * (px(1) - px(0));
      b1 = 2 * (py(1) - py(0));
      c1 = square_term(0) - square_term(1);
      a2 = 2 * (px(2) - px(0));
      b2 = 2 * (py(2) - py(0));
      c2 = square_term(0) - square_term(2);
      det = a1 * b2 - a2 * b1;
      fix.x = '0;
      fix.y = '0;
      fix.solved = 0;
      if (det >= 1678 || det <= -1678) begin
         fix.x = 24'(clip((c1 * b2 - c2 * b1) / det, -8388608, 8388607));
         fix.y = 24'(clip((a1 * c2 - a2 * c1) / det, -8388608, 8388607));
         fix.solved = 1;
      end
      fresh = '{0, 0, 0};
      owed.push_back(fix);
   endfunction

   function void check(position_fix_type got);
      position_fix_type want;
      if (owed.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected fix x=%0d y=%0d solved=%0b", got.x, got.y, got.solved);
         return;
      end
      want = owed.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.solved !== want.solved) begin
         mismatches++;
         if (mismatches <= 10)
            $display("fix mismatch: expected x=%0d y=%0d solved=%0b, got x=%0d y=%0d solved=%0b",
                     want.x, want.y, want.solved, got.x, got.y, got.solved);
      end
   endfunction
endclass

module tb_rssi_kalman_trilateration;

   // Cycles without any accepted transaction before the run is declared hung. The
   // slowest legal gap is a settle pause or a frame that completes a set, queued behind
   // a full four-entry queue and a stalled rsp side.
   localparam int HANG_LIMIT = 20000;
   // Cycles allowed for frames that produce no fix to drain before a register write.
   localparam int SETTLE_CYCLES = 700;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   quiet = 0;          // when set, neither side inserts idle cycles
   int   stall_cycles = 0;
   ranging_scoreboard sb;

   rkt_req_if req_ch();
   rkt_rsp_if rsp_ch();
   rkt_csr_if csr_ch();

   rssi_kalman_trilateration dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   always #2 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.source_address = '0;
      req_ch.signal_strength = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      rsp_ch.ready = 1'b0;
      sb = new();
      sb.clear();
   end

   // The receiver stalls in about one cycle out of five unless the quiet stretch is on.
   always @(negedge clock) begin
      rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= 20);
   end

   // Every accepted rsp transaction is checked against the oldest owed fix.
   always @(posedge clock) begin
      position_fix_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.x = rsp_ch.position_x;
         got.y = rsp_ch.position_y;
         got.solved = rsp_ch.solved;
         sb.check(got);
      end
   end

   // Watchdog on cycles in which no channel moves a transaction.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= HANG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [rkt_pkg::CSR_INDEX_W-1:0] idx, logic [47:0] data);
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data = data;
      do @(posedge clock); while (!csr_ch.ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // Sends one frame; valid stays high into the next call so back-to-back frames need
   // no drop. Random idle cycles are inserted before the frame unless quiet is set.
   task automatic send_frame(logic [47:0] addr, logic signed [7:0] rssi);
      @(negedge clock);
      while (!quiet && $urandom_range(0, 99) < 20) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.source_address = addr;
      req_ch.signal_strength = rssi;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_frame(addr, rssi);
   endtask

   // Waits until every owed fix has arrived, then lets frames that complete no set
   // finish inside the block.
   task automatic drain();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_anchors(logic [47:0] a0, logic [47:0] a1, logic [47:0] a2,
                              logic [31:0] p0, logic [31:0] p1, logic [31:0] p2);
      drain();
      write_reg(rkt_pkg::REG_ANCHOR0_ADDR, a0);
      write_reg(rkt_pkg::REG_ANCHOR1_ADDR, a1);
      write_reg(rkt_pkg::REG_ANCHOR2_ADDR, a2);
      write_reg(rkt_pkg::REG_ANCHOR0_POS, {16'h0, p0});
      write_reg(rkt_pkg::REG_ANCHOR1_POS, {16'h0, p1});
      write_reg(rkt_pkg::REG_ANCHOR2_POS, {16'h0, p2});
   endtask

   function automatic logic [47:0] rand_addr();
      return {16'($urandom), $urandom};
   endfunction

   // A packed position: either a realistic spot within about two metres or fully random.
   function automatic logic [31:0] rand_pos();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return {16'($signed($urandom_range(0, 16384)) - 16'sd8192),
              16'($signed($urandom_range(0, 16384)) - 16'sd8192)};
   endfunction

   // Random frames: mostly from the configured anchors so that sets complete, the rest
   // from random senders. RSSI is mostly in a realistic band, sometimes anywhere.
   task automatic random_frames(int count, bit pause_midway);
      logic [47:0] addr;
      int          pick;
      logic signed [7:0] rssi;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 85) addr = sb.anchor_addr[pick % 3];
         else addr = rand_addr();
         if ($urandom_range(0, 3) == 0) rssi = 8'($urandom);
         else rssi = 8'(-$signed($urandom_range(30, 95)));
         send_frame(addr, rssi);
         if (pause_midway && n == count / 2) drain();
      end
   endtask

   initial begin
      logic [47:0] a0, a1, a2;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // After reset every anchor address is zero, so sender zero always lands on
      // anchor 0 (lowest index wins) and no set ever completes.
      send_frame(48'h0, -8'sd128);
      send_frame(48'h0, 8'sd127);
      send_frame(48'hFFFF_FFFF_FFFF, -8'sd60);

      // Directed part on distinct anchors with the reset geometry.
      a0 = 48'h0000_0000_0001;
      a1 = 48'hFFFF_FFFF_FFFF;
      a2 = 48'hA5A5_5A5A_0F0F;
      set_anchors(a0, a1, a2, rkt_pkg::ANCHOR0_POS_RESET, rkt_pkg::ANCHOR1_POS_RESET,
                  rkt_pkg::ANCHOR2_POS_RESET);
      write_reg(3'd6, 48'hFFFF_FFFF_FFFF);    // unmapped indexes are ignored
      write_reg(3'd7, 48'h1234_5678_9ABC);
      send_frame(a0, 8'sd127);
      send_frame(48'h5A5A_A5A5_F0F0, -8'sd50);  // unknown sender
      send_frame(a1, -8'sd128);
      send_frame(a1, -8'sd128);                 // repeat on a fresh anchor
      send_frame(a2, 8'sd0);
      send_frame(a0, -8'sd40);
      send_frame(a1, -8'sd70);
      send_frame(a2, -8'sd1);

      // Duplicate addresses: anchor 1 shares anchor 0's address and is never updated.
      set_anchors(a0, a0, a2, rkt_pkg::ANCHOR0_POS_RESET, rkt_pkg::ANCHOR1_POS_RESET,
                  rkt_pkg::ANCHOR2_POS_RESET);
      send_frame(a0, -8'sd55);
      send_frame(a2, -8'sd65);
      send_frame(a0, -8'sd45);

      // Degenerate geometry: all anchors in one spot, the fix comes back unsolved.
      set_anchors(a0, a1, a2, 32'h1000_1000, 32'h1000_1000, 32'h1000_1000);
      send_frame(a0, -8'sd60);
      send_frame(a1, -8'sd61);
      send_frame(a2, -8'sd62);

      // Extreme coordinates, which drive the position into saturation.
      set_anchors(a0, a1, a2, 32'h8000_7FFF, 32'h7FFF_8000, 32'h0001_FFFF);
      send_frame(a0, -8'sd128);
      send_frame(a1, 8'sd127);
      send_frame(a2, -8'sd90);

      // Random phases, each with its own configuration. The third runs without idles
      // on either side, and the second pauses the sender until all fixes are in.
      for (int phase = 0; phase < 5; phase++) begin
         a0 = rand_addr();
         a1 = rand_addr();
         a2 = rand_addr();
         if (phase == 4) set_anchors(~a1, a1, a2, rand_pos(), rand_pos(), rand_pos());
         else set_anchors(a0, a1, a2, rand_pos(), rand_pos(), rand_pos());
         quiet = (phase == 2);
         random_frames(380, phase == 1);
      end
      quiet = 0;

      drain();
      if (sb.mismatches == 0 && sb.owed.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/rkt_pkg.sv
hw/rtl/rkt_if.sv
hw/rtl/rkt_front.sv
hw/rtl/rkt_queue.sv
hw/rtl/rkt_div.sv
hw/rtl/rkt_back.sv
hw/rtl/rssi_kalman_trilateration.sv
tb/tb_rssi_kalman_trilateration.sv
